// ----- hw/rtl/gbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared codes, counter constants and the 2-bit saturating counter step for
// the gshare predictor.
// ----------------------------------------------------------------------------
package gbp_pkg;

  localparam int CTR_W = 2;

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  localparam logic [CTR_W-1:0] CTR_RESET = 2'd2;
  localparam logic [CTR_W-1:0] CTR_MAX   = 2'd3;
  localparam logic [CTR_W-1:0] CTR_MIN   = 2'd0;

  typedef logic [CTR_W-1:0] ctr_t;

  // Saturating step: up on taken, down on not taken.
  function automatic ctr_t ctr_next(input ctr_t cur, input logic tkn);
    ctr_t res;
    res = cur;
    if (tkn) begin
      if (cur != CTR_MAX) res = cur + 2'd1;
    end else begin
      if (cur != CTR_MIN) res = cur - 2'd1;
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/gbp_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_fifo
// Two-entry queue between the front (index hash) and the back (table
// read-modify-write). Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module gbp_fifo #(
  parameter int WIDTH = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/gbp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_front
// Accepts items, hashes PC with the global history into a table index and
// advances the history on updates. Queues {opcode, taken, index}.
// ----------------------------------------------------------------------------
module gbp_front #(
  parameter int HISTORY_BITS = 10,
  parameter int IDX_W        = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic [31:0]        in_pc,
  input  logic               in_taken,
  input  logic               clearing,
  input  logic               q_full,
  output logic               q_push,
  output logic [IDX_W+1:0]   q_data
);

  logic [HISTORY_BITS-1:0] hist_r, hist_nxt;
  logic [HISTORY_BITS-1:0] hash;
  logic [IDX_W-1:0]        idx;

  assign in_ready = !clearing && !q_full;
  assign q_push   = in_valid && in_ready;
  assign hash     = in_pc[HISTORY_BITS+1:2] ^ hist_r;

  generate
    if (IDX_W <= HISTORY_BITS) begin : g_wrap
      // drop the upper hash bits: index wraps over the table
      assign idx = hash[IDX_W-1:0];
    end else begin : g_ext
      assign idx = {{(IDX_W-HISTORY_BITS){1'b0}}, hash};
    end
  endgenerate

  assign q_data = {in_opcode, in_taken, idx};

  always_comb begin
    hist_nxt = hist_r;
    if (q_push && in_opcode == gbp_pkg::OP_UPDATE) begin
      hist_nxt = {hist_r[HISTORY_BITS-2:0], in_taken};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= HISTORY_BITS'(1);
    end else begin
      hist_r <= hist_nxt;
    end
  end

endmodule

// ----- hw/rtl/gbp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_back
// Pattern table with registered read, counter update and write-back, with
// forwarding between back-to-back items on the same index. Clears the table
// to weakly taken after reset, one entry a cycle.
// ----------------------------------------------------------------------------
module gbp_back #(
  parameter int TABLE_DEPTH = 1024,
  parameter int IDX_W       = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  logic [IDX_W+1:0]   q_data,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_predict_taken,
  output logic [1:0]         out_counter_value
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  gbp_pkg::ctr_t    mem [TABLE_DEPTH];

  logic             clearing_r;
  logic [IDX_W-1:0] clr_cnt_r;

  logic             q_op, q_tkn;
  logic [IDX_W-1:0] q_idx;

  logic             v1_r, v1_nxt;
  logic             op1_r, tk1_r;
  logic [IDX_W-1:0] idx1_r;
  gbp_pkg::ctr_t    rd_data_r;
  logic             fwd_r;
  gbp_pkg::ctr_t    fwd_val_r;

  logic             out_valid_r, out_valid_nxt;
  gbp_pkg::ctr_t    out_ctr_r;

  logic             adv, wr_en;
  gbp_pkg::ctr_t    ctr_cur, ctr_new;

  assign q_op  = q_data[IDX_W+1];
  assign q_tkn = q_data[IDX_W];
  assign q_idx = q_data[IDX_W-1:0];

  assign ctr_cur = fwd_r ? fwd_val_r : rd_data_r;
  assign ctr_new = gbp_pkg::ctr_next(ctr_cur, tk1_r);

  assign adv   = v1_r && (!out_valid_r || out_ready);
  assign wr_en = adv && (op1_r == gbp_pkg::OP_UPDATE);
  assign q_pop = q_valid && !clearing_r && (!v1_r || adv);

  always_comb begin
    v1_nxt = v1_r;
    if (q_pop)    v1_nxt = 1'b1;
    else if (adv) v1_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (adv)            out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_IDX) clearing_r <= 1'b0;
      end
      v1_r        <= v1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item registers of the read stage
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op1_r     <= q_op;
      tk1_r     <= q_tkn;
      idx1_r    <= q_idx;
      // the read below sees the table before this edge's write
      fwd_r     <= wr_en && (q_idx == idx1_r);
      fwd_val_r <= ctr_new;
    end
    if (adv) begin
      out_ctr_r <= ctr_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_cnt_r] <= gbp_pkg::CTR_RESET;
    end else if (wr_en) begin
      mem[idx1_r] <= ctr_new;
    end
    if (q_pop) begin
      rd_data_r <= mem[q_idx];
    end
  end

  assign clearing          = clearing_r;
  assign out_valid         = out_valid_r;
  assign out_predict_taken = out_ctr_r[1];
  assign out_counter_value = out_ctr_r;

endmodule

// ----- hw/rtl/gshare_branch_predictor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gshare_branch_predictor
// Gshare predictor: 2-bit counters indexed by PC[H+1:2] xor global history.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   in      | in_valid / in_ready  | in_opcode, in_pc, in_taken
//   out     | out_valid / out_ready| out_predict_taken, out_counter_value
//
// One item per cycle sustained while out_ready is high; a result passes from the
// queue entry, written at the accepting edge, through the registered table
// read and the output register.
// After reset the table is cleared one entry a cycle; in_ready stays low until
// it is done. TABLE_DEPTH must be a power of two; the block does not check it.
// A stalled output holds its item; the queue keeps accepting until it fills.
// ----------------------------------------------------------------------------
module gshare_branch_predictor #(
  parameter int HISTORY_BITS = 10,
  parameter int TABLE_DEPTH  = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [31:0] in_pc,
  input  logic        in_taken,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_predict_taken,
  output logic [1:0]  out_counter_value
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int Q_W   = IDX_W + 2;

  logic           clearing;
  logic           q_full, q_push, q_pop, q_valid;
  logic [Q_W-1:0] q_push_data, q_pop_data;

  gbp_front #(
    .HISTORY_BITS (HISTORY_BITS),
    .IDX_W        (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_pc     (in_pc),
    .in_taken  (in_taken),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  gbp_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_pop_data)
  );

  gbp_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_data            (q_pop_data),
    .q_pop             (q_pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_predict_taken (out_predict_taken),
    .out_counter_value (out_counter_value)
  );

endmodule

// ----- hw/rtl/gbp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_checker
// Port-level checks for the gshare predictor, bound to the top level.
// ----------------------------------------------------------------------------
module gbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_predict_taken,
  input logic [1:0] out_counter_value
);

  // table clear holds off input after reset
  a_no_accept_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("in_ready high in the cycle after reset");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high in the cycle after reset");

  a_pred_matches_ctr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_predict_taken == out_counter_value[1]))
    else $error("prediction disagrees with counter value");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_counter_value) && $stable(out_predict_taken)))
    else $error("stalled result item changed or dropped");

endmodule

bind gshare_branch_predictor gbp_checker u_gbp_checker (.*);
